@@ hdl/h264_sps_header_parser_defines.svh @@
// ----------------------------------------------------------------------------
// SPS parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef H264_SPS_HEADER_PARSER_DEFINES_SVH
`define H264_SPS_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define SPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// SPS parser package
// Shared types, syntax steps, field kinds and aspect ratio tables.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned PrefixBytes = 4;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrW    = $clog2(FifoDepth);

  localparam logic [6:0] KIND_IDLE = 7'd0;
  localparam logic [6:0] KIND_UE   = 7'd64;
  localparam logic [6:0] KIND_SE   = 7'd65;

  localparam logic [3:0] ERR_NONE    = 4'd0;
  localparam logic [3:0] ERR_PROFILE = 4'd1;
  localparam logic [3:0] ERR_SPSID   = 4'd2;
  localparam logic [3:0] ERR_CHROMA  = 4'd3;
  localparam logic [3:0] ERR_DEPTH   = 4'd4;
  localparam logic [3:0] ERR_FRMNUM  = 4'd5;
  localparam logic [3:0] ERR_POCTYPE = 4'd6;
  localparam logic [3:0] ERR_POCCYC  = 4'd7;
  localparam logic [3:0] ERR_REFFRM  = 4'd8;
  localparam logic [3:0] ERR_DIRECT  = 4'd9;
  localparam logic [3:0] ERR_TRUNC   = 4'd10;

  typedef struct packed {
    logic [7:0] data;
    logic       parse;
    logic       last;
  } item_t;

  typedef enum logic [51:0] {
    S_HDR = 52'd1 << 0, S_PROFILE = 52'd1 << 1, S_CONSTR = 52'd1 << 2,
    S_LEVEL = 52'd1 << 3, S_SPSID = 52'd1 << 4, S_CHROMA = 52'd1 << 5,
    S_SEPPLANE = 52'd1 << 6, S_DEPTHL = 52'd1 << 7, S_DEPTHC = 52'd1 << 8,
    S_BYPASS = 52'd1 << 9, S_MATRIX = 52'd1 << 10, S_LISTFLAG = 52'd1 << 11,
    S_DELTA = 52'd1 << 12, S_FRAMENUM = 52'd1 << 13, S_POCTYPE = 52'd1 << 14,
    S_POCLSB = 52'd1 << 15, S_POCZERO = 52'd1 << 16, S_OFFNONREF = 52'd1 << 17,
    S_OFFTB = 52'd1 << 18, S_CYCLE = 52'd1 << 19, S_OFFREF = 52'd1 << 20,
    S_REFFRAMES = 52'd1 << 21, S_GAPS = 52'd1 << 22, S_WIDTH = 52'd1 << 23,
    S_HEIGHT = 52'd1 << 24, S_FRAMEONLY = 52'd1 << 25, S_MBAFF = 52'd1 << 26,
    S_DIRECT = 52'd1 << 27, S_CROPFLAG = 52'd1 << 28, S_CROPL = 52'd1 << 29,
    S_CROPR = 52'd1 << 30, S_CROPT = 52'd1 << 31, S_CROPB = 52'd1 << 32,
    S_VUIFLAG = 52'd1 << 33, S_ARFLAG = 52'd1 << 34, S_ARIDC = 52'd1 << 35,
    S_SARW = 52'd1 << 36, S_SARH = 52'd1 << 37, S_OVERFLAG = 52'd1 << 38,
    S_OVERAPP = 52'd1 << 39, S_VSFLAG = 52'd1 << 40, S_VSFMT = 52'd1 << 41,
    S_COLFLAG = 52'd1 << 42, S_COLDESC = 52'd1 << 43, S_CLFLAG = 52'd1 << 44,
    S_CLTOP = 52'd1 << 45, S_CLBOT = 52'd1 << 46, S_TIMFLAG = 52'd1 << 47,
    S_UNITS = 52'd1 << 48, S_TSCALE = 52'd1 << 49, S_FIXED = 52'd1 << 50,
    S_DONE = 52'd1 << 51
  } step_e;

  function automatic logic [6:0] field_kind(step_e s);
    logic [6:0] k;
    case (s)
      S_HDR, S_PROFILE, S_CONSTR, S_LEVEL, S_ARIDC: k = 7'd8;
      S_SEPPLANE, S_BYPASS, S_MATRIX, S_LISTFLAG, S_POCZERO, S_GAPS,
      S_FRAMEONLY, S_MBAFF, S_DIRECT, S_CROPFLAG, S_VUIFLAG, S_ARFLAG,
      S_OVERFLAG, S_OVERAPP, S_VSFLAG, S_COLFLAG, S_CLFLAG, S_TIMFLAG,
      S_FIXED: k = 7'd1;
      S_SARW, S_SARH: k = 7'd16;
      S_VSFMT: k = 7'd4;
      S_COLDESC: k = 7'd24;
      S_UNITS, S_TSCALE: k = 7'd32;
      S_DELTA, S_OFFNONREF, S_OFFTB, S_OFFREF: k = KIND_SE;
      S_DONE: k = KIND_IDLE;
      default: k = KIND_UE;
    endcase
    return k;
  endfunction

  function automatic logic [15:0] sar_num(logic [3:0] idc);
    logic [15:0] r;
    case (idc)
      4'd2: r = 16'd12;  4'd3: r = 16'd10;  4'd4: r = 16'd16;
      4'd5: r = 16'd40;  4'd6: r = 16'd24;  4'd7: r = 16'd20;
      4'd8: r = 16'd32;  4'd9: r = 16'd80;  4'd10: r = 16'd18;
      4'd11: r = 16'd15; 4'd12: r = 16'd64; 4'd13: r = 16'd160;
      default: r = 16'd1;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sar_den(logic [3:0] idc);
    logic [15:0] r;
    case (idc)
      4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd10, 4'd11: r = 16'd11;
      4'd5, 4'd9, 4'd12: r = 16'd33;
      4'd13: r = 16'd99;
      default: r = 16'd1;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/sps_front.sv @@
// ----------------------------------------------------------------------------
// SPS front end
// Skips the start-code prefix and marks emulation-prevention bytes.
// ----------------------------------------------------------------------------
module sps_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output sps_pkg::item_t  item_o
);

  logic [2:0] bcnt_q, bcnt_d;
  logic [1:0] zrun_q, zrun_d;
  logic       in_prefix, epb;

  assign in_prefix = bcnt_q < 3'(sps_pkg::PrefixBytes);
  assign epb       = !in_prefix && zrun_q == 2'd2 && byte_i == 8'h03;

  always_comb begin
    bcnt_d = bcnt_q;
    zrun_d = zrun_q;
    if (accept_i) begin
      if (in_prefix) begin
        bcnt_d = bcnt_q + 3'd1;
      end else if (epb) begin
        zrun_d = 2'd0;
      end else if (byte_i != 8'd0) begin
        zrun_d = 2'd0;
      end else if (zrun_q != 2'd2) begin
        zrun_d = zrun_q + 2'd1;
      end
      if (last_i) begin
        bcnt_d = 3'd0;
        zrun_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= 3'd0;
      zrun_q <= 2'd0;
    end else begin
      bcnt_q <= bcnt_d;
      zrun_q <= zrun_d;
    end
  end

  assign item_o.data  = byte_i;
  assign item_o.parse = !in_prefix && !epb;
  assign item_o.last  = last_i;

endmodule

@@ hdl/sps_fifo.sv @@
// ----------------------------------------------------------------------------
// SPS byte queue
// Small register queue between front end and bit parser.
// ----------------------------------------------------------------------------
module sps_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sps_pkg::item_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sps_pkg::item_t  item_o
);

  localparam int unsigned PW = sps_pkg::FifoPtrW;

  sps_pkg::item_t mem_q [sps_pkg::FifoDepth];
  logic [PW-1:0]  wr_q, rd_q;
  logic [PW:0]    cnt_q;

  assign full_o  = cnt_q == (PW+1)'(sps_pkg::FifoDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

@@ hdl/sps_back.sv @@
// ----------------------------------------------------------------------------
// SPS bit parser
// Decodes the syntax one bit per cycle while it holds a byte and registers the result transfer.
// ----------------------------------------------------------------------------
`include "h264_sps_header_parser_defines.svh"

module sps_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            want_aspect_i,
  input  logic            valid_i,
  input  sps_pkg::item_t  item_i,
  output logic            pop_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic [71:0]     m_data_o
);

  sps_pkg::step_e step_q, step_d;
  logic        busy_q, busy_d, lastb_q, lastb_d;
  logic [3:0]  left_q, left_d;
  logic [7:0]  sh_q, sh_d;
  logic [5:0]  bc_q, bc_d;
  logic [32:0] acc_q, acc_d;
  logic [7:0]  prof_q, prof_d, li_q, li_d, sl_q, sl_d;
  logic [1:0]  cf_q, cf_d;
  logic        fo_q, fo_d;
  logic [6:0]  ci_q, ci_d;
  logic [31:0] wmb_q, wmb_d, hmu_q, hmu_d, crr_q, crr_d, crb_q, crb_d;
  logic [15:0] arw_q, arw_d, arh_q, arh_d;
  logic [3:0]  err_q, err_d;

  logic        ovld_q;
  logic [68:0] odat_q;

  logic        out_free, done_now, ld_out, feed, fin, bitv;
  logic [6:0]  kind;
  logic [33:0] ext;
  logic [31:0] v;
  logic [7:0]  d8, nxt, li_inc;
  logic [6:0]  ci_inc;

  assign out_free = !ovld_q || m_ready_i;
  assign done_now = busy_q && left_q == 4'd0 && (!lastb_q || out_free);
  assign ld_out   = done_now && lastb_q;
  assign pop_o    = valid_i && (!busy_q || done_now);
  assign feed     = busy_q && left_q != 4'd0;
  assign bitv     = sh_q[7];
  assign kind     = sps_pkg::field_kind(step_q);
  assign ext      = {acc_q, bitv};
  assign d8       = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
  assign nxt      = sl_q + d8;
  assign li_inc   = li_q + 8'd1;
  assign ci_inc   = ci_q + 7'd1;

  always_comb begin
    step_d = step_q; bc_d = bc_q; acc_d = acc_q; prof_d = prof_q; li_d = li_q;
    sl_d = sl_q; cf_d = cf_q; fo_d = fo_q; ci_d = ci_q; wmb_d = wmb_q;
    hmu_d = hmu_q; crr_d = crr_q; crb_d = crb_q; arw_d = arw_q; arh_d = arh_q;
    err_d = err_q; fin = 1'b0; v = '0;
    busy_d = busy_q; left_d = left_q; sh_d = sh_q; lastb_d = lastb_q;

    if (feed) begin
      left_d = left_q - 4'd1;
      sh_d   = {sh_q[6:0], 1'b0};
    end

    if (feed && kind != sps_pkg::KIND_IDLE) begin
      if (kind < sps_pkg::KIND_UE) begin
        acc_d = {acc_q[31:0], bitv};
        bc_d  = bc_q + 6'd1;
        fin   = bc_d == kind[5:0];
        v     = acc_d[31:0];
      end else if (acc_q == '0) begin
        if (!bitv) begin
          if (bc_q != 6'd63) bc_d = bc_q + 6'd1;
        end else begin
          acc_d = 33'd1;
          fin   = bc_q == 6'd0;
        end
      end else begin
        acc_d = (ext > {2'b0, 32'd0} + 34'h1_0000_0000) ? 33'h1_0000_0000 : ext[32:0];
        bc_d  = bc_q - 6'd1;
        fin   = bc_d == 6'd0;
        v     = 32'(acc_d - 33'd1);
      end
      if (fin) begin
        acc_d = '0;
        bc_d  = '0;
        case (step_q)
          sps_pkg::S_HDR:      step_d = sps_pkg::S_PROFILE;
          sps_pkg::S_PROFILE: begin
            prof_d = v[7:0];
            if (v == 32'd66 || v == 32'd77 || v == 32'd88 || v == 32'd100 ||
                v == 32'd110 || v == 32'd122 || v == 32'd244 || v == 32'd44) begin
              step_d = sps_pkg::S_CONSTR;
            end else begin
              err_d = sps_pkg::ERR_PROFILE; step_d = sps_pkg::S_DONE;
            end
          end
          sps_pkg::S_CONSTR:   step_d = sps_pkg::S_LEVEL;
          sps_pkg::S_LEVEL:    step_d = sps_pkg::S_SPSID;
          sps_pkg::S_SPSID: begin
            if (v >= 32'd32) begin
              err_d = sps_pkg::ERR_SPSID; step_d = sps_pkg::S_DONE;
            end else begin
              step_d = (prof_q >= 8'd100) ? sps_pkg::S_CHROMA : sps_pkg::S_FRAMENUM;
            end
          end
          sps_pkg::S_CHROMA: begin
            if (v > 32'd3) begin
              err_d = sps_pkg::ERR_CHROMA; step_d = sps_pkg::S_DONE;
            end else begin
              cf_d   = v[1:0];
              step_d = (v == 32'd3) ? sps_pkg::S_SEPPLANE : sps_pkg::S_DEPTHL;
            end
          end
          sps_pkg::S_SEPPLANE: step_d = sps_pkg::S_DEPTHL;
          sps_pkg::S_DEPTHL, sps_pkg::S_DEPTHC: begin
            if (v > 32'd4) begin
              err_d = sps_pkg::ERR_DEPTH; step_d = sps_pkg::S_DONE;
            end else begin
              step_d = (step_q == sps_pkg::S_DEPTHL) ? sps_pkg::S_DEPTHC
                                                     : sps_pkg::S_BYPASS;
            end
          end
          sps_pkg::S_BYPASS:   step_d = sps_pkg::S_MATRIX;
          sps_pkg::S_MATRIX: begin
            li_d   = '0;
            step_d = v[0] ? sps_pkg::S_LISTFLAG : sps_pkg::S_FRAMENUM;
          end
          sps_pkg::S_LISTFLAG: begin
            if (v[0]) begin
              sl_d = 8'd8; ci_d = '0; step_d = sps_pkg::S_DELTA;
            end else begin
              li_d   = li_inc;
              step_d = (li_inc >= ((cf_q == 2'd3) ? 8'd12 : 8'd8)) ?
                       sps_pkg::S_FRAMENUM : sps_pkg::S_LISTFLAG;
            end
          end
          sps_pkg::S_DELTA: begin
            if (nxt != 8'd0) sl_d = nxt;
            ci_d = ci_inc;
            if (nxt == 8'd0 || ci_inc >= ((li_q < 8'd6) ? 7'd16 : 7'd64)) begin
              li_d   = li_inc;
              step_d = (li_inc >= ((cf_q == 2'd3) ? 8'd12 : 8'd8)) ?
                       sps_pkg::S_FRAMENUM : sps_pkg::S_LISTFLAG;
            end
          end
          sps_pkg::S_FRAMENUM: begin
            if (v > 32'd12) begin
              err_d = sps_pkg::ERR_FRMNUM; step_d = sps_pkg::S_DONE;
            end else begin
              step_d = sps_pkg::S_POCTYPE;
            end
          end
          sps_pkg::S_POCTYPE: begin
            if (v > 32'd2) begin
              err_d = sps_pkg::ERR_POCTYPE; step_d = sps_pkg::S_DONE;
            end else if (v == 32'd0) begin
              step_d = sps_pkg::S_POCLSB;
            end else if (v == 32'd1) begin
              step_d = sps_pkg::S_POCZERO;
            end else begin
              step_d = sps_pkg::S_REFFRAMES;
            end
          end
          sps_pkg::S_POCLSB:    step_d = sps_pkg::S_REFFRAMES;
          sps_pkg::S_POCZERO:   step_d = sps_pkg::S_OFFNONREF;
          sps_pkg::S_OFFNONREF: step_d = sps_pkg::S_OFFTB;
          sps_pkg::S_OFFTB:     step_d = sps_pkg::S_CYCLE;
          sps_pkg::S_CYCLE: begin
            if (v[31:8] != '0) begin
              err_d = sps_pkg::ERR_POCCYC; step_d = sps_pkg::S_DONE;
            end else begin
              li_d   = v[7:0];
              step_d = (v == 32'd0) ? sps_pkg::S_REFFRAMES : sps_pkg::S_OFFREF;
            end
          end
          sps_pkg::S_OFFREF: begin
            li_d = li_q - 8'd1;
            if (li_d == 8'd0) step_d = sps_pkg::S_REFFRAMES;
          end
          sps_pkg::S_REFFRAMES: begin
            if (v > 32'd16) begin
              err_d = sps_pkg::ERR_REFFRM; step_d = sps_pkg::S_DONE;
            end else begin
              step_d = sps_pkg::S_GAPS;
            end
          end
          sps_pkg::S_GAPS:   step_d = sps_pkg::S_WIDTH;
          sps_pkg::S_WIDTH:  begin wmb_d = v; step_d = sps_pkg::S_HEIGHT; end
          sps_pkg::S_HEIGHT: begin hmu_d = v; step_d = sps_pkg::S_FRAMEONLY; end
          sps_pkg::S_FRAMEONLY: begin
            fo_d   = v[0];
            step_d = v[0] ? sps_pkg::S_DIRECT : sps_pkg::S_MBAFF;
          end
          sps_pkg::S_MBAFF:  step_d = sps_pkg::S_DIRECT;
          sps_pkg::S_DIRECT: begin
            if (!fo_q && !v[0]) begin
              err_d = sps_pkg::ERR_DIRECT; step_d = sps_pkg::S_DONE;
            end else begin
              step_d = sps_pkg::S_CROPFLAG;
            end
          end
          sps_pkg::S_CROPFLAG: begin
            if (v[0]) step_d = sps_pkg::S_CROPL;
            else step_d = want_aspect_i ? sps_pkg::S_VUIFLAG : sps_pkg::S_DONE;
          end
          sps_pkg::S_CROPL: step_d = sps_pkg::S_CROPR;
          sps_pkg::S_CROPR: begin crr_d = v; step_d = sps_pkg::S_CROPT; end
          sps_pkg::S_CROPT: step_d = sps_pkg::S_CROPB;
          sps_pkg::S_CROPB: begin
            crb_d  = v;
            step_d = want_aspect_i ? sps_pkg::S_VUIFLAG : sps_pkg::S_DONE;
          end
          sps_pkg::S_VUIFLAG: step_d = v[0] ? sps_pkg::S_ARFLAG : sps_pkg::S_DONE;
          sps_pkg::S_ARFLAG:  step_d = v[0] ? sps_pkg::S_ARIDC : sps_pkg::S_OVERFLAG;
          sps_pkg::S_ARIDC: begin
            if (v < 32'd14) begin
              arw_d = sps_pkg::sar_num(v[3:0]);
              arh_d = sps_pkg::sar_den(v[3:0]);
            end
            step_d = (v == 32'd255) ? sps_pkg::S_SARW : sps_pkg::S_OVERFLAG;
          end
          sps_pkg::S_SARW: begin arw_d = v[15:0]; step_d = sps_pkg::S_SARH; end
          sps_pkg::S_SARH: begin arh_d = v[15:0]; step_d = sps_pkg::S_OVERFLAG; end
          sps_pkg::S_OVERFLAG: step_d = v[0] ? sps_pkg::S_OVERAPP : sps_pkg::S_VSFLAG;
          sps_pkg::S_OVERAPP:  step_d = sps_pkg::S_VSFLAG;
          sps_pkg::S_VSFLAG:   step_d = v[0] ? sps_pkg::S_VSFMT : sps_pkg::S_CLFLAG;
          sps_pkg::S_VSFMT:    step_d = sps_pkg::S_COLFLAG;
          sps_pkg::S_COLFLAG:  step_d = v[0] ? sps_pkg::S_COLDESC : sps_pkg::S_CLFLAG;
          sps_pkg::S_COLDESC:  step_d = sps_pkg::S_CLFLAG;
          sps_pkg::S_CLFLAG:   step_d = v[0] ? sps_pkg::S_CLTOP : sps_pkg::S_TIMFLAG;
          sps_pkg::S_CLTOP:    step_d = sps_pkg::S_CLBOT;
          sps_pkg::S_CLBOT:    step_d = sps_pkg::S_TIMFLAG;
          sps_pkg::S_TIMFLAG:  step_d = v[0] ? sps_pkg::S_UNITS : sps_pkg::S_DONE;
          sps_pkg::S_UNITS:    step_d = sps_pkg::S_TSCALE;
          sps_pkg::S_TSCALE:   step_d = sps_pkg::S_FIXED;
          sps_pkg::S_FIXED:    step_d = sps_pkg::S_DONE;
          default:             step_d = sps_pkg::S_DONE;
        endcase
      end
    end

    if (done_now) busy_d = 1'b0;
    if (ld_out) begin
      step_d = sps_pkg::S_HDR; bc_d = '0; acc_d = '0; prof_d = '0; cf_d = 2'd1;
      fo_d = 1'b0; li_d = '0; ci_d = '0; sl_d = 8'd8; wmb_d = '0; hmu_d = '0;
      crr_d = '0; crb_d = '0; arw_d = 16'd1; arh_d = 16'd1; err_d = '0;
    end
    if (pop_o) begin
      busy_d  = 1'b1;
      sh_d    = item_i.data;
      left_d  = item_i.parse ? 4'd8 : 4'd0;
      lastb_d = item_i.last;
    end
  end

  // result fields from the registered syntax state
  logic [3:0]  ferr;
  logic [36:0] fw;
  logic [37:0] fh, fcw, fch;
  logic [37:0] rw, rh;
  logic [15:0] ow, oh;
  logic        two_fields;

  assign ferr = (err_q != sps_pkg::ERR_NONE) ? err_q :
                (step_q != sps_pkg::S_DONE) ? sps_pkg::ERR_TRUNC : sps_pkg::ERR_NONE;
  assign two_fields = !fo_q;
  assign fw  = ({5'd0, wmb_q} + 37'd1) << 4;
  assign fh  = (({6'd0, hmu_q} + 38'd1) << 4) << two_fields;
  assign fcw = {6'd0, crr_q} << ((cf_q == 2'd1 || cf_q == 2'd2) ? 1 : 0);
  assign fch = ({6'd0, crb_q} << two_fields) << ((cf_q == 2'd1) ? 1 : 0);
  assign rw  = (fcw > {1'b0, fw}) ? '0 : {1'b0, fw} - fcw;
  assign rh  = (fch > fh) ? '0 : fh - fch;
  assign ow  = (rw[37:16] != '0) ? 16'hFFFF : rw[15:0];
  assign oh  = (rh[37:16] != '0) ? 16'hFFFF : rh[15:0];

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      if (ferr == sps_pkg::ERR_NONE) begin
        odat_q <= {arh_q, arw_q, oh, ow, ferr, 1'b1};
      end else begin
        odat_q <= {64'd0, ferr, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; left_q <= '0; lastb_q <= 1'b0; ovld_q <= 1'b0;
      step_q <= sps_pkg::S_HDR; bc_q <= '0; acc_q <= '0; prof_q <= '0;
      cf_q <= 2'd1; fo_q <= 1'b0; li_q <= '0; ci_q <= '0; sl_q <= 8'd8;
      wmb_q <= '0; hmu_q <= '0; crr_q <= '0; crb_q <= '0;
      arw_q <= 16'd1; arh_q <= 16'd1; err_q <= '0; sh_q <= '0;
    end else begin
      busy_q <= busy_d; left_q <= left_d; lastb_q <= lastb_d; sh_q <= sh_d;
      ovld_q <= ld_out ? 1'b1 : (m_ready_i ? 1'b0 : ovld_q);
      step_q <= step_d; bc_q <= bc_d; acc_q <= acc_d; prof_q <= prof_d;
      cf_q <= cf_d; fo_q <= fo_d; li_q <= li_d; ci_q <= ci_d; sl_q <= sl_d;
      wmb_q <= wmb_d; hmu_q <= hmu_d; crr_q <= crr_d; crb_q <= crb_d;
      arw_q <= arw_d; arh_q <= arh_d; err_q <= err_d;
    end
  end

  assign m_valid_o = ovld_q;
  assign m_data_o  = {3'd0, odat_q};

  `SPS_ASSERT_IMP(a_load_free, ld_out, !ovld_q || m_ready_i, "result overwritten")
  `SPS_ASSERT_NXT(a_load_valid, ld_out, ovld_q, "result lost")
  `SPS_ASSERT_IMP(a_ok_code, ovld_q, m_data_o[0] == (m_data_o[4:1] == sps_pkg::ERR_NONE),
                  "ok flag disagrees with error code")

endmodule

@@ hdl/h264_sps_header_parser.sv @@
// ----------------------------------------------------------------------------
// H.264 SPS header parser
// Top level: front end, byte queue, bit parser.
// ----------------------------------------------------------------------------
// Takes one NAL byte per transfer (tlast on the final byte) and returns one
// result per NAL unit. A byte that carries syntax goes through eight bit steps
// plus a hand-off in the bit parser; prefix and emulation-prevention bytes take
// only the hand-off. A four-entry queue decouples input from the parser, and
// the result sits in an output register, so new bytes are taken while it waits.
module h264_sps_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // want_aspect
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] nal_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // ok, error_code[4], pic_width[16],
                                        // pic_height[16], aspect_width[16],
                                        // aspect_height[16], zero pad
);

  logic           want_q;
  logic           full, accept, q_valid, pop;
  sps_pkg::item_t f_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_q <= 1'b1;
    end else if (cfg_we_i) begin
      want_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  sps_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .item_o   (f_item)
  );

  sps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  sps_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .want_aspect_i (want_q),
    .valid_i       (q_valid),
    .item_i        (q_item),
    .pop_o         (pop),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_data_o      (m_axis_tdata_o)
  );

endmodule
